// ===== src/pnc_pkg.sv =====
`timescale 1ns / 1ps
package pnc_pkg;

  // command codes
  typedef enum logic [2:0] {
    OP_TONE_ATTACK = 3'd0,
    OP_NOTE_OFF    = 3'd1,
    OP_MUTE_ALL    = 3'd2,
    OP_SET_ENV     = 3'd3,
    OP_SET_VOLUME  = 3'd4,
    OP_SET_MIXER   = 3'd5
  } op_e;

  // kinds of write runs handed from front to back
  typedef enum logic [1:0] {
    KIND_TONE  = 2'd0,
    KIND_OFF   = 2'd1,
    KIND_MUTE  = 2'd2,
    KIND_MIXER = 2'd3
  } kind_e;

  // chip register numbers
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_VOL_A     = 4'd8;
  localparam logic [3:0] REG_VOL_B     = 4'd9;
  localparam logic [3:0] REG_VOL_C     = 4'd10;
  localparam logic [3:0] REG_ENV_LO    = 4'd11;
  localparam logic [3:0] REG_ENV_HI    = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

  localparam logic [4:0] ENV_VOLUME   = 5'h1F;
  localparam logic [3:0] VOLUME_RESET = 4'hF;
  localparam logic [7:0] MIXER_RESET  = 8'hF8;
  localparam logic [1:0] CH_C         = 2'd2;
  localparam logic [1:0] CH_NONE      = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // one run of register writes, with everything the back needs
  typedef struct packed {
    kind_e       kind;
    logic [1:0]  ch;
    logic [15:0] period;
    logic [15:0] env_period;
    logic [3:0]  env_shape;
    logic        use_env;
    logic [4:0]  vol;
    logic [4:0]  melody;
    logic        sync;
    logic [7:0]  mixer;
    logic [2:0]  last_step;
  } job_t;

  function automatic logic [3:0] period_addr(input logic [1:0] ch);
    period_addr = {1'b0, ch, 1'b0};
  endfunction

  function automatic logic [3:0] volume_addr(input logic [1:0] ch);
    volume_addr = REG_VOL_A + {2'b00, ch};
  endfunction

endpackage

// ===== src/pnc_front.sv =====
`timescale 1ns / 1ps
module pnc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  logic [2:0]        operation_i,
  input  logic [1:0]        channel_i,
  input  logic [15:0]       period_value_i,
  input  logic [7:0]        channel_mask_i,
  input  logic [7:0]        shape_value_i,
  input  logic [7:0]        volume_value_i,
  input  logic [7:0]        mixer_value_i,
  output logic              push_o,
  output pnc_pkg::job_t     job_o,
  input  logic              full_i
);
  import pnc_pkg::*;

  logic [2:0]  env_ch_q, env_ch_d;
  logic [3:0]  env_shape_q, env_shape_d;
  logic [15:0] env_period_q, env_period_d;
  logic [3:0]  fix_vol_q [3];
  logic [3:0]  fix_vol_d [3];
  logic [7:0]  mixer_q, mixer_d;
  logic [4:0]  melody_q, melody_d;
  logic        accept;
  logic [2:0]  mask;
  logic        use_env;
  logic [4:0]  vol;

  assign cmd_ready_o = !full_i;
  assign accept      = cmd_valid_i && !full_i;
  assign mask        = channel_mask_i[2:0];

  always_comb begin
    use_env = 1'b0;
    vol     = 5'd0;
    if (channel_i != CH_NONE && period_value_i != 16'd0) begin
      use_env = env_ch_q[channel_i];
      vol     = use_env ? ENV_VOLUME : {1'b0, fix_vol_q[channel_i]};
    end
  end

  always_comb begin
    env_ch_d     = env_ch_q;
    env_shape_d  = env_shape_q;
    env_period_d = env_period_q;
    fix_vol_d    = fix_vol_q;
    mixer_d      = mixer_q;
    melody_d     = melody_q;
    push_o       = 1'b0;
    job_o        = '0;
    job_o.ch         = channel_i;
    job_o.period     = period_value_i;
    job_o.env_period = env_period_q;
    job_o.env_shape  = env_shape_q;
    job_o.use_env    = use_env;
    job_o.vol        = vol;
    case (operation_i)
      OP_TONE_ATTACK: begin
        if (channel_i != CH_NONE) begin
          push_o          = 1'b1;
          job_o.kind      = KIND_TONE;
          job_o.last_step = use_env ? 3'd5 : 3'd2;
          if (channel_i == CH_C) begin
            melody_d   = vol;
            job_o.sync = 1'b1;
          end
        end
      end
      OP_NOTE_OFF: begin
        if (channel_i != CH_NONE) begin
          push_o          = 1'b1;
          job_o.kind      = KIND_OFF;
          job_o.last_step = 3'd0;
          if (channel_i == CH_C) begin
            melody_d   = 5'd0;
            job_o.sync = 1'b1;
          end
        end
      end
      OP_MUTE_ALL: begin
        push_o          = 1'b1;
        job_o.kind      = KIND_MUTE;
        job_o.last_step = 3'd2;
        melody_d        = 5'd0;
        job_o.sync      = 1'b1;
      end
      OP_SET_ENV: begin
        if (mask != 3'd0) begin
          env_shape_d  = shape_value_i[3:0];
          env_period_d = period_value_i;
          env_ch_d     = mask;
        end
      end
      OP_SET_VOLUME: begin
        if (mask != 3'd0) begin
          env_ch_d = env_ch_q & ~mask;
          for (int i = 0; i < 3; i++) begin
            if (mask[i]) fix_vol_d[i] = volume_value_i[3:0];
          end
        end
      end
      OP_SET_MIXER: begin
        push_o          = 1'b1;
        job_o.kind      = KIND_MIXER;
        job_o.last_step = 3'd0;
        mixer_d         = mixer_value_i;
      end
      default: ;
    endcase
    job_o.melody = melody_d;
    job_o.mixer  = mixer_d;
    push_o       = push_o && accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_ch_q     <= 3'd0;
      env_shape_q  <= 4'd0;
      env_period_q <= 16'd0;
      for (int i = 0; i < 3; i++) fix_vol_q[i] <= VOLUME_RESET;
      mixer_q      <= MIXER_RESET;
      melody_q     <= 5'd0;
    end else if (accept) begin
      env_ch_q     <= env_ch_d;
      env_shape_q  <= env_shape_d;
      env_period_q <= env_period_d;
      fix_vol_q    <= fix_vol_d;
      mixer_q      <= mixer_d;
      melody_q     <= melody_d;
    end
  end

endmodule

// ===== src/pnc_queue.sv =====
`timescale 1ns / 1ps
module pnc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pnc_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pnc_pkg::job_t job_o
);
  import pnc_pkg::*;

  job_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== src/pnc_back.sv =====
`timescale 1ns / 1ps
module pnc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  pnc_pkg::job_t job_i,
  output logic          pop_o,
  output logic          wr_valid_o,
  input  logic          wr_ready_i,
  output logic [3:0]    reg_addr_o,
  output logic [7:0]    reg_data_o,
  output logic          last_o,
  output logic [4:0]    melody_c_volume_o,
  output logic          c_volume_sync_o,
  output logic [7:0]    mixer_mirror_o
);
  import pnc_pkg::*;

  logic [2:0] step_q;
  logic       valid_q;
  logic [3:0] addr_q, addr_d;
  logic [7:0] data_q, data_d;
  logic       last_q, melody_sync_q;
  logic [4:0] melody_q;
  logic [7:0] mixer_q;
  logic       load, is_last;

  assign load    = job_valid_i && (!valid_q || wr_ready_i);
  assign is_last = (step_q == job_i.last_step);
  assign pop_o   = load && is_last;

  // register write for the current step of the head run
  always_comb begin
    addr_d = volume_addr(job_i.ch);
    data_d = 8'd0;
    case (job_i.kind)
      KIND_TONE: begin
        case (step_q)
          3'd0: begin
            addr_d = period_addr(job_i.ch);
            data_d = job_i.period[7:0];
          end
          3'd1: begin
            addr_d = period_addr(job_i.ch) + 4'd1;
            data_d = job_i.period[15:8];
          end
          3'd2: begin
            if (job_i.use_env) begin
              addr_d = REG_ENV_LO;
              data_d = job_i.env_period[7:0];
            end else begin
              data_d = {3'b000, job_i.vol};
            end
          end
          3'd3: begin
            addr_d = REG_ENV_HI;
            data_d = job_i.env_period[15:8];
          end
          3'd4: begin
            addr_d = REG_ENV_SHAPE;
            data_d = {4'b0000, job_i.env_shape};
          end
          default: data_d = {3'b000, job_i.vol};
        endcase
      end
      KIND_MUTE: addr_d = REG_VOL_A + {1'b0, step_q};
      KIND_MIXER: begin
        addr_d = REG_MIXER;
        data_d = job_i.mixer;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= 3'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        step_q  <= is_last ? 3'd0 : step_q + 3'd1;
      end else if (wr_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q        <= addr_d;
      data_q        <= data_d;
      last_q        <= is_last;
      melody_q      <= job_i.melody;
      melody_sync_q <= job_i.sync;
      mixer_q       <= job_i.mixer;
    end
  end

  assign wr_valid_o        = valid_q;
  assign reg_addr_o        = addr_q;
  assign reg_data_o        = data_q;
  assign last_o            = last_q;
  assign melody_c_volume_o = melody_q;
  assign c_volume_sync_o   = melody_sync_q;
  assign mixer_mirror_o    = mixer_q;

endmodule

// ===== src/psg_note_command_sequencer.sv =====
`timescale 1ns / 1ps
// psg note command sequencer: turns music commands into sound-chip register
// writes. Each command transaction on the slave side yields a run of zero to
// six write transactions on the master side, one per cycle while the master
// side is ready, tlast on the last write of a run. Tone attack gives three
// writes (six when the channel rides the envelope), note off and set mixer
// one, mute all three; tone attack and note off on channel 3 and unused codes
// give none; set envelope and set fixed volume give none and only touch
// internal state. A command is taken every cycle while the four-entry run
// queue has room; the master side sustains one write per cycle while ready,
// so the output write port sets the rate.
// After reset the mixer mirror reads 0xF8 but no R7 write is sent; issue
// set mixer 0xF8 if the chip needs it.
module psg_note_command_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] operation, [4:3] channel, [20:5] period_value, [28:21] channel_mask,
  // [36:29] shape_value, [44:37] volume_value, [52:45] mixer_value, rest zero
  input  logic [55:0] s_axis_tdata,
  // register write side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] reg_addr, [11:4] reg_data, [16:12] melody_c_volume,
  // [24:17] mixer_mirror, rest zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // [0] c_volume_sync
  output logic        m_axis_tuser
);
  import pnc_pkg::*;

  logic       push, full, job_valid, pop;
  job_t       push_job, head_job;
  logic [3:0] reg_addr;
  logic [7:0] reg_data;
  logic [4:0] melody_c_volume;
  logic [7:0] mixer_mirror;

  // front: decodes commands, holds envelope / volume / mixer state
  pnc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (s_axis_tvalid),
    .cmd_ready_o    (s_axis_tready),
    .operation_i    (s_axis_tdata[2:0]),
    .channel_i      (s_axis_tdata[4:3]),
    .period_value_i (s_axis_tdata[20:5]),
    .channel_mask_i (s_axis_tdata[28:21]),
    .shape_value_i  (s_axis_tdata[36:29]),
    .volume_value_i (s_axis_tdata[44:37]),
    .mixer_value_i  (s_axis_tdata[52:45]),
    .push_o         (push),
    .job_o          (push_job),
    .full_i         (full)
  );

  // run queue between decode and write sequencing
  pnc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (head_job)
  );

  // back: steps through each run, one registered write per cycle while ready
  pnc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_valid_i       (job_valid),
    .job_i             (head_job),
    .pop_o             (pop),
    .wr_valid_o        (m_axis_tvalid),
    .wr_ready_i        (m_axis_tready),
    .reg_addr_o        (reg_addr),
    .reg_data_o        (reg_data),
    .last_o            (m_axis_tlast),
    .melody_c_volume_o (melody_c_volume),
    .c_volume_sync_o   (m_axis_tuser),
    .mixer_mirror_o    (mixer_mirror)
  );

  assign m_axis_tdata = {7'd0, mixer_mirror, melody_c_volume, reg_data, reg_addr};

endmodule

// ===== dv/psg_note_command_sequencer_tb.sv =====
`timescale 1ns / 1ps
module psg_note_command_sequencer_tb;
  import pnc_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int RANDOM_COMMANDS = 276;
  localparam int DRAIN_CYCLES = 20;

  // one chip register write as seen on the master side
  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
    logic [4:0] melody;
    logic       sync;
    logic [7:0] mirror;
  } chip_write_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // shadow of the sequencer state
  logic [2:0]  env_ch_mask;
  logic [3:0]  env_shape_q;
  logic [15:0] env_period_q;
  logic [3:0]  fixed_vol_q [3];
  logic [7:0]  mixer_q;
  logic [4:0]  melody_c_q;

  chip_write_t pending_writes [$];
  int          errors;
  int          long_hold;
  bit          tx_busy_run;
  bit          rx_busy_run;

  psg_note_command_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    else if (r < 93) return $urandom_range(1, 3);
    else return $urandom_range(4, 24);
  endfunction

  // work out the register writes one command causes and queue them
  task automatic predict_chip_writes(input logic [55:0] cmd);
    logic [2:0]  op;
    logic [1:0]  ch;
    logic [15:0] period;
    logic [2:0]  mask;
    logic [3:0]  shape;
    logic [3:0]  vol_in;
    logic [7:0]  mix;
    logic [3:0]  wr_addr [6];
    logic [7:0]  wr_data [6];
    logic [4:0]  vol;
    logic        sync;
    int          n;
    chip_write_t w;
    op     = cmd[2:0];
    ch     = cmd[4:3];
    period = cmd[20:5];
    mask   = cmd[23:21];        // upper mask bits are don't care
    shape  = cmd[32:29];
    vol_in = cmd[40:37];
    mix    = cmd[52:45];
    n      = 0;
    sync   = 1'b0;
    case (op)
      OP_TONE_ATTACK: begin
        if (ch != CH_NONE) begin
          wr_addr[0] = {1'b0, ch, 1'b0};
          wr_data[0] = period[7:0];
          wr_addr[1] = {1'b0, ch, 1'b1};
          wr_data[1] = period[15:8];
          n = 2;
          if (period == 16'd0) begin
            vol = 5'd0;
          end else if (env_ch_mask[ch]) begin
            // channel rides the envelope: reload the shared generator
            wr_addr[2] = REG_ENV_LO;
            wr_data[2] = env_period_q[7:0];
            wr_addr[3] = REG_ENV_HI;
            wr_data[3] = env_period_q[15:8];
            wr_addr[4] = REG_ENV_SHAPE;
            wr_data[4] = {4'd0, env_shape_q};
            n = 5;
            vol = ENV_VOLUME;
          end else begin
            vol = {1'b0, fixed_vol_q[ch]};
          end
          wr_addr[n] = REG_VOL_A + {2'b00, ch};
          wr_data[n] = {3'd0, vol};
          n++;
          if (ch == CH_C) begin
            melody_c_q = vol;
            sync = 1'b1;
          end
        end
      end
      OP_NOTE_OFF: begin
        if (ch != CH_NONE) begin
          wr_addr[0] = REG_VOL_A + {2'b00, ch};
          wr_data[0] = 8'd0;
          n = 1;
          if (ch == CH_C) begin
            melody_c_q = 5'd0;
            sync = 1'b1;
          end
        end
      end
      OP_MUTE_ALL: begin
        wr_addr[0] = REG_VOL_A;
        wr_addr[1] = REG_VOL_B;
        wr_addr[2] = REG_VOL_C;
        wr_data[0] = 8'd0;
        wr_data[1] = 8'd0;
        wr_data[2] = 8'd0;
        n = 3;
        melody_c_q = 5'd0;
        sync = 1'b1;
      end
      OP_SET_ENV: begin
        if (mask != 3'd0) begin
          env_shape_q  = shape;
          env_period_q = period;
          env_ch_mask  = mask;
        end
      end
      OP_SET_VOLUME: begin
        if (mask != 3'd0) begin
          env_ch_mask = env_ch_mask & ~mask;
          for (int i = 0; i < 3; i++)
            if (mask[i]) fixed_vol_q[i] = vol_in;
        end
      end
      OP_SET_MIXER: begin
        mixer_q = mix;
        wr_addr[0] = REG_MIXER;
        wr_data[0] = mix;
        n = 1;
      end
      default: ;  // spare codes are dropped
    endcase
    for (int k = 0; k < n; k++) begin
      w.addr   = wr_addr[k];
      w.data   = wr_data[k];
      w.last   = (k == n - 1);
      w.melody = melody_c_q;
      w.sync   = sync;
      w.mirror = mixer_q;
      pending_writes.push_back(w);
    end
  endtask

  task automatic check_chip_write();
    chip_write_t got;
    chip_write_t want;
    got.addr   = m_axis_tdata[3:0];
    got.data   = m_axis_tdata[11:4];
    got.last   = m_axis_tlast;
    got.melody = m_axis_tdata[16:12];
    got.sync   = m_axis_tuser;
    got.mirror = m_axis_tdata[24:17];
    if (pending_writes.size() == 0) begin
      errors++;
      $display("%0t: unexpected write addr=%h data=%h", $time, got.addr, got.data);
    end else begin
      want = pending_writes.pop_front();
      if (got !== want || m_axis_tdata[31:25] !== 7'd0) begin
        errors++;
        $display("%0t: write mismatch expected addr=%h data=%h last=%b melody=%h sync=%b mix=%h",
                 $time, want.addr, want.data, want.last, want.melody, want.sync, want.mirror);
        $display("%0t:                  actual addr=%h data=%h last=%b melody=%h sync=%b mix=%h",
                 $time, got.addr, got.data, got.last, got.melody, got.sync, got.mirror);
      end
    end
  endtask

  // commands are predicted before writes are checked in the same cycle
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) predict_chip_writes(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_chip_write();
  end

  // write side: random readiness, plus a long hold-off counted here
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      int unsigned rx_wait;
      @(negedge clk_i);
      if (long_hold > 0) begin
        m_axis_tready <= 1'b0;
        long_hold--;
      end else if (rx_wait > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
        rx_wait = rx_busy_run ? 0 : pick_gap();
      end
    end
  end

  // called and returning at a falling edge; valid stays high for the next command
  task automatic send_command(input logic [2:0] op, input logic [1:0] ch,
                              input logic [15:0] period, input logic [7:0] mask,
                              input logic [7:0] shape, input logic [7:0] vol,
                              input logic [7:0] mix);
    int unsigned gap;
    gap = tx_busy_run ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'd0, mix, vol, shape, mask, period, ch, op};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // reset values: fixed volume 15 on channels A and C, mirror 0xF8, no envelope
  task automatic test_reset_state();
    send_command(OP_TONE_ATTACK, 2'd0, 16'h1234, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OP_TONE_ATTACK, CH_C, 16'h0001, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OP_SET_MIXER, 2'd0, 16'h0000, 8'h00, 8'h00, 8'h00, MIXER_RESET);
  endtask

  task automatic test_each_command();
    // silence and the period extremes
    send_command(OP_TONE_ATTACK, 2'd1, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OP_TONE_ATTACK, CH_C, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00);
    // channel 3 does nothing
    send_command(OP_TONE_ATTACK, CH_NONE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_command(OP_NOTE_OFF, CH_NONE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OP_NOTE_OFF, 2'd0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OP_NOTE_OFF, 2'd1, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OP_NOTE_OFF, CH_C, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
    // zero mask leaves the envelope alone, upper mask bits are ignored
    send_command(OP_SET_ENV, 2'd0, 16'hBEEF, 8'hF8, 8'hFF, 8'h00, 8'h00);
    send_command(OP_SET_ENV, 2'd0, 16'hA55A, 8'hFF, 8'hFE, 8'hFF, 8'hFF);
    send_command(OP_TONE_ATTACK, 2'd0, 16'h00FF, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OP_TONE_ATTACK, 2'd1, 16'hFF00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OP_TONE_ATTACK, CH_C, 16'h5555, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OP_TONE_ATTACK, CH_C, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
    // fixed volume pulls channel B off the envelope
    send_command(OP_SET_VOLUME, 2'd0, 16'h0000, 8'hFA, 8'h00, 8'hF3, 8'h00);
    send_command(OP_SET_VOLUME, 2'd0, 16'h0000, 8'hF8, 8'h00, 8'h00, 8'h00);
    send_command(OP_TONE_ATTACK, 2'd1, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OP_TONE_ATTACK, 2'd0, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OP_SET_VOLUME, 2'd0, 16'h0000, 8'h07, 8'h00, 8'h00, 8'h00);
    send_command(OP_TONE_ATTACK, CH_C, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OP_MUTE_ALL, CH_NONE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_command(OP_SET_MIXER, 2'd0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(OP_SET_MIXER, 2'd0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_command(OP_SPARE_6, 2'd0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_command(OP_SPARE_7, CH_C, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // write side holds off while six-write attacks keep coming back to back
  task automatic test_output_stall();
    send_command(OP_SET_ENV, 2'd0, 16'h3C3C, 8'h07, 8'h0D, 8'h00, 8'h00);
    tx_busy_run = 1'b1;
    long_hold = 120;
    for (int i = 0; i < 16; i++)
      send_command(OP_TONE_ATTACK, 2'(i % 3), 16'(32'h0200 + i),
                   8'h00, 8'h00, 8'h00, 8'h00);
    tx_busy_run = 1'b0;
  endtask

  task automatic test_random_commands();
    logic [2:0]  op;
    logic [1:0]  ch;
    logic [15:0] period;
    logic [7:0]  mask;
    int unsigned r;
    for (int i = 0; i < RANDOM_COMMANDS; i++) begin
      // stretches with no idling on one or both sides
      if (i % 40 == 0) begin
        tx_busy_run = ($urandom_range(0, 3) == 0);
        rx_busy_run = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 38) op = OP_TONE_ATTACK;
      else if (r < 50) op = OP_NOTE_OFF;
      else if (r < 56) op = OP_MUTE_ALL;
      else if (r < 70) op = OP_SET_ENV;
      else if (r < 84) op = OP_SET_VOLUME;
      else if (r < 96) op = OP_SET_MIXER;
      else if (r < 98) op = OP_SPARE_6;
      else op = OP_SPARE_7;
      ch = ($urandom_range(0, 9) == 0) ? CH_NONE : 2'($urandom_range(0, 2));
      period = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
      mask = ($urandom_range(0, 7) == 0) ? {5'($urandom_range(0, 31)), 3'd0}
                                         : 8'($urandom_range(0, 255));
      send_command(op, ch, period, mask, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    tx_busy_run = 1'b0;
    rx_busy_run = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    errors        = 0;
    long_hold     = 0;
    tx_busy_run   = 1'b0;
    rx_busy_run   = 1'b0;
    env_ch_mask   = 3'd0;
    env_shape_q   = 4'd0;
    env_period_q  = 16'd0;
    for (int i = 0; i < 3; i++) fixed_vol_q[i] = VOLUME_RESET;
    mixer_q       = MIXER_RESET;
    melody_c_q    = 5'd0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_each_command();
    test_output_stall();
    test_random_commands();

    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== psg_note_command_sequencer.f =====
src/pnc_pkg.sv
src/pnc_front.sv
src/pnc_queue.sv
src/pnc_back.sv
src/psg_note_command_sequencer.sv
dv/psg_note_command_sequencer_tb.sv
